### hw/rtl/rpsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsc_pkg: shared types and constants for the pattern syntax checker
// Holds the error codes, the scan phase encoding and the byte class helpers.
// ----------------------------------------------------------------------------
package rpsc_pkg;

  typedef enum logic [3:0] {
    E_NONE       = 4'd0,
    E_ESC_END    = 4'd1,
    E_DECIMAL    = 4'd2,
    E_PROPERTY   = 4'd3,
    E_UNICODE    = 4'd4,
    E_HEX        = 4'd5,
    E_CLASS      = 4'd6,
    E_PAREN      = 4'd7,
    E_BRACKET    = 4'd8,
    E_NOTHING    = 4'd9,
    E_INCOMPLETE = 4'd10,
    E_ORDER      = 4'd11
  } err_t;

  typedef enum logic [4:0] {
    PH_PLAIN, PH_ESC, PH_DEC_ZERO, PH_DEC_NUM, PH_PROP_P, PH_PROP_FIRST,
    PH_PROP_NAME, PH_UNI_U, PH_UNI_HEX4, PH_UNI_BR_FIRST, PH_UNI_BR,
    PH_HEX_U, PH_HEX_N1, PH_HEX_N2, PH_BR_OPEN, PH_BR_MIN, PH_BR_MAX,
    PH_LAZY, PH_GRP_OPEN, PH_GRP_Q, PH_GRP_LT
  } phase_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return is_dig(c) || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)
        || c == 8'h3d || c == 8'h2d;
  endfunction

  // saturating v*10+d, v*10 via shifts and add
  function automatic logic [31:0] acc_dec(input logic [31:0] v, input logic [7:0] c);
    logic [35:0] d;
    logic [35:0] s;
    begin
      d = {32'd0, c[3:0]};
      s = ({4'd0, v} << 3) + ({4'd0, v} << 1) + d;
      return (s[35:32] != 4'd0) ? 32'hFFFF_FFFF : s[31:0];
    end
  endfunction

endpackage

### hw/rtl/rpsc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsc_scan: one scan step of the phase machine
// Pure combinational: takes the state and a byte, returns the next state and
// whether the byte has to be scanned again in the new phase.
// ----------------------------------------------------------------------------
module rpsc_scan
  import rpsc_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic          umode,
  input  logic [7:0]    c,
  input  phase_t        ph_i,
  input  logic          cls_i,
  input  logic          lq_i,
  input  logic [CW-1:0] depth_i,
  input  logic [CW-1:0] grp_i,
  input  logic [31:0]   bref_i,
  input  logic [31:0]   num_i,
  input  logic [31:0]   qmin_i,
  input  logic          comma_i,
  input  logic [2:0]    dig_i,
  input  logic [3:0]    err_i,
  output phase_t        ph_o,
  output logic          cls_o,
  output logic          lq_o,
  output logic [CW-1:0] depth_o,
  output logic [CW-1:0] grp_o,
  output logic [31:0]   bref_o,
  output logic [31:0]   num_o,
  output logic [31:0]   qmin_o,
  output logic          comma_o,
  output logic [2:0]    dig_o,
  output logic [3:0]    err_o,
  output logic          again
);

  localparam logic [CW-1:0] CMAX = '1;

  logic [3:0] e;
  logic       esc_done;
  logic       mal;
  logic [2:0] dinc;

  always_comb begin
    ph_o = ph_i; cls_o = cls_i; lq_o = lq_i; depth_o = depth_i; grp_o = grp_i;
    bref_o = bref_i; num_o = num_i; qmin_o = qmin_i; comma_o = comma_i;
    dig_o = dig_i; again = 1'b0; e = E_NONE; esc_done = 1'b0; mal = 1'b0;
    dinc = dig_i + 3'd1;
    unique case (ph_i)
      PH_PLAIN: begin
        if (c == 8'h5c) ph_o = PH_ESC;
        else if (cls_i) begin
          if (c == 8'h5d) begin cls_o = 1'b0; lq_o = 1'b1; end
        end else if (c == 8'h5b) cls_o = 1'b1;
        else if (c == 8'h28) begin
          if (depth_i != CMAX) depth_o = depth_i + 1'b1;
          lq_o = 1'b1; ph_o = PH_GRP_OPEN;
        end else if (c == 8'h29) begin
          if (depth_i == '0) e = E_PAREN;
          else begin depth_o = depth_i - 1'b1; lq_o = 1'b1; end
        end else if (c == 8'h7b) ph_o = PH_BR_OPEN;
        else if (c == 8'h2a || c == 8'h2b || c == 8'h3f) begin
          if (!lq_i) e = E_NOTHING;
          else begin lq_o = 1'b0; ph_o = PH_LAZY; end
        end else if ((c == 8'h5d || c == 8'h7d) && umode) e = E_BRACKET;
        else lq_o = 1'b1;
      end
      PH_ESC: begin
        if (umode && is_dig(c)) begin
          if (c == 8'h30) ph_o = PH_DEC_ZERO;
          else begin num_o = {28'd0, c[3:0]}; ph_o = PH_DEC_NUM; end
        end else if (c == 8'h70 || c == 8'h50) ph_o = PH_PROP_P;
        else if (c == 8'h75) ph_o = PH_UNI_U;
        else if (c == 8'h78) begin
          dig_o = 3'd0; ph_o = umode ? PH_HEX_U : PH_HEX_N1;
        end else esc_done = 1'b1;
      end
      PH_DEC_ZERO: begin
        if (is_dig(c)) e = E_DECIMAL;
        else begin esc_done = 1'b1; again = 1'b1; end
      end
      PH_DEC_NUM: begin
        if (is_dig(c)) num_o = acc_dec(num_i, c);
        else begin
          if (num_i > bref_i) bref_o = num_i;
          esc_done = 1'b1; again = 1'b1;
        end
      end
      PH_PROP_P: begin
        if (c == 8'h7b) ph_o = PH_PROP_FIRST; else e = E_PROPERTY;
      end
      PH_PROP_FIRST, PH_PROP_NAME: begin
        if (c == 8'h7d) begin
          if (ph_i == PH_PROP_FIRST) e = E_PROPERTY; else esc_done = 1'b1;
        end else if (is_name(c)) ph_o = PH_PROP_NAME;
        else e = E_PROPERTY;
      end
      PH_UNI_U: begin
        if (c == 8'h7b) ph_o = PH_UNI_BR_FIRST;
        else if (is_hex(c)) begin dig_o = 3'd1; ph_o = PH_UNI_HEX4; end
        else e = E_UNICODE;
      end
      PH_UNI_HEX4: begin
        if (!is_hex(c)) e = E_UNICODE;
        else if (dinc >= 3'd4) begin dig_o = 3'd0; esc_done = 1'b1; end
        else dig_o = dinc;
      end
      PH_UNI_BR_FIRST, PH_UNI_BR: begin
        if (c == 8'h7d) begin
          if (ph_i == PH_UNI_BR_FIRST) e = E_UNICODE; else esc_done = 1'b1;
        end else if (is_hex(c)) ph_o = PH_UNI_BR;
        else e = E_UNICODE;
      end
      PH_HEX_U: begin
        if (!is_hex(c)) e = E_HEX;
        else if (dinc >= 3'd2) begin dig_o = 3'd0; esc_done = 1'b1; end
        else dig_o = dinc;
      end
      PH_HEX_N1: begin
        if (is_hex(c)) ph_o = PH_HEX_N2;
        else begin esc_done = 1'b1; again = 1'b1; end
      end
      PH_HEX_N2: begin
        esc_done = 1'b1; again = !is_hex(c);
      end
      PH_BR_OPEN: begin
        if (!is_dig(c)) mal = 1'b1;
        else begin
          qmin_o = {28'd0, c[3:0]}; comma_o = 1'b0; ph_o = PH_BR_MIN;
        end
      end
      PH_BR_MIN: begin
        if (is_dig(c)) qmin_o = acc_dec(qmin_i, c);
        else if (c == 8'h2c) begin
          comma_o = 1'b1; num_o = '0; dig_o = 3'd0; ph_o = PH_BR_MAX;
        end else if (c == 8'h7d) begin lq_o = 1'b0; ph_o = PH_LAZY; end
        else mal = 1'b1;
      end
      PH_BR_MAX: begin
        if (is_dig(c)) begin num_o = acc_dec(num_i, c); dig_o = 3'd1; end
        else if (c != 8'h7d) mal = 1'b1;
        else if (dig_i != 3'd0 && num_i != 32'hFFFF_FFFF && qmin_i > num_i) e = E_ORDER;
        else begin
          comma_o = 1'b0; dig_o = 3'd0; lq_o = 1'b0; ph_o = PH_LAZY;
        end
      end
      PH_LAZY: begin
        ph_o = PH_PLAIN; again = (c != 8'h3f);
      end
      PH_GRP_OPEN: begin
        if (c == 8'h3f) ph_o = PH_GRP_Q;
        else begin
          if (grp_i != CMAX) grp_o = grp_i + 1'b1;
          ph_o = PH_PLAIN; again = 1'b1;
        end
      end
      PH_GRP_Q: begin
        ph_o = PH_PLAIN;
        if (c == 8'h3a || c == 8'h3d || c == 8'h21) ;
        else if (c == 8'h3c) ph_o = PH_GRP_LT;
        else begin
          if (grp_i != CMAX) grp_o = grp_i + 1'b1;
          again = !(c == 8'h50 || c == 8'h69 || c == 8'h6d || c == 8'h73 || c == 8'h78);
        end
      end
      PH_GRP_LT: begin
        ph_o = PH_PLAIN;
        if (!(c == 8'h3d || c == 8'h21)) begin
          if (grp_i != CMAX) grp_o = grp_i + 1'b1;
          again = 1'b1;
        end
      end
      default: begin
        ph_o = PH_PLAIN; again = 1'b1;
      end
    endcase
    if (esc_done) begin
      ph_o = PH_PLAIN;
      if (!cls_i) lq_o = 1'b1;
    end
    if (mal) begin
      comma_o = 1'b0;
      if (umode) e = E_INCOMPLETE;
      else begin lq_o = 1'b1; ph_o = PH_PLAIN; again = 1'b1; end
    end
    err_o = err_i;
    if (e != E_NONE) begin
      err_o = e;
      again = 1'b0;
    end
  end

endmodule

### hw/rtl/regexp_pattern_syntax_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regexp_pattern_syntax_checker: byte-serial regular-expression syntax check
// Scans a pattern one byte a beat and reports the first syntax error.
// ----------------------------------------------------------------------------
// Feed the pattern one byte per input beat with operation 0, then one beat
// with operation 1 to close it. Every input beat gives exactly one output
// beat: on a byte it shows the sticky error so far, on the end beat it gives
// the verdict (finished=1, pattern_valid when no error) and clears the scan
// state for the next pattern. The block takes one beat per clock with no gap:
// the scan of a byte and the end check are done combinationally in the
// accepting cycle, by at most two cascaded scan steps (a byte is scanned once
// more only after a phase falls back to the plain token phase), and the
// result is loaded into an output register that drains while the next beat
// comes in. The result shows in the next cycle; one not taken holds in_ready
// low until out_ready rises. unicode_mode may be written only while idle.
// COUNTER_BITS sets the width of the paren depth and group counters.
// ----------------------------------------------------------------------------
module regexp_pattern_syntax_checker
  import rpsc_pkg::*;
#(
  parameter int COUNTER_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [7:0] pattern_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] error_code,
  output logic       finished,
  output logic       pattern_valid
);

  localparam int CW = COUNTER_BITS;
  localparam logic [CW-1:0] CMAX = '1;
  // a rescan always lands in the plain token phase, which never rescans
  localparam int STEPS = 2;

  // configuration
  logic umode;

  // scan state
  phase_t        ph;
  logic          cls, lq, comma;
  logic [CW-1:0] depth, grp;
  logic [31:0]   bref, num, qmin;
  logic [2:0]    dig;
  logic [3:0]    err;

  // chain of scan steps, index 0 is the current state
  phase_t        s_ph    [STEPS+1];
  logic          s_cls   [STEPS+1];
  logic          s_lq    [STEPS+1];
  logic          s_comma [STEPS+1];
  logic [CW-1:0] s_depth [STEPS+1];
  logic [CW-1:0] s_grp   [STEPS+1];
  logic [31:0]   s_bref  [STEPS+1];
  logic [31:0]   s_num   [STEPS+1];
  logic [31:0]   s_qmin  [STEPS+1];
  logic [2:0]    s_dig   [STEPS+1];
  logic [3:0]    s_err   [STEPS+1];
  logic          s_go    [STEPS+1];
  logic          s_again [STEPS];

  logic          accept;
  logic [3:0]    end_err;
  logic [CW-1:0] end_grp;
  logic [31:0]   end_bref;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  assign s_ph[0] = ph;       assign s_cls[0] = cls;     assign s_lq[0] = lq;
  assign s_comma[0] = comma; assign s_depth[0] = depth; assign s_grp[0] = grp;
  assign s_bref[0] = bref;   assign s_num[0] = num;     assign s_qmin[0] = qmin;
  assign s_dig[0] = dig;     assign s_err[0] = err;
  assign s_go[0] = (err == E_NONE);

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    phase_t        n_ph;
    logic          n_cls, n_lq, n_comma;
    logic [CW-1:0] n_depth, n_grp;
    logic [31:0]   n_bref, n_num, n_qmin;
    logic [2:0]    n_dig;
    logic [3:0]    n_err;

    rpsc_scan #(.CW(CW)) u_scan (
      .umode(umode), .c(pattern_byte),
      .ph_i(s_ph[i]), .cls_i(s_cls[i]), .lq_i(s_lq[i]), .depth_i(s_depth[i]),
      .grp_i(s_grp[i]), .bref_i(s_bref[i]), .num_i(s_num[i]), .qmin_i(s_qmin[i]),
      .comma_i(s_comma[i]), .dig_i(s_dig[i]), .err_i(s_err[i]),
      .ph_o(n_ph), .cls_o(n_cls), .lq_o(n_lq), .depth_o(n_depth), .grp_o(n_grp),
      .bref_o(n_bref), .num_o(n_num), .qmin_o(n_qmin), .comma_o(n_comma),
      .dig_o(n_dig), .err_o(n_err), .again(s_again[i])
    );

    // a step only applies while the previous one asked for a rescan
    assign s_ph[i+1]    = s_go[i] ? n_ph    : s_ph[i];
    assign s_cls[i+1]   = s_go[i] ? n_cls   : s_cls[i];
    assign s_lq[i+1]    = s_go[i] ? n_lq    : s_lq[i];
    assign s_comma[i+1] = s_go[i] ? n_comma : s_comma[i];
    assign s_depth[i+1] = s_go[i] ? n_depth : s_depth[i];
    assign s_grp[i+1]   = s_go[i] ? n_grp   : s_grp[i];
    assign s_bref[i+1]  = s_go[i] ? n_bref  : s_bref[i];
    assign s_num[i+1]   = s_go[i] ? n_num   : s_num[i];
    assign s_qmin[i+1]  = s_go[i] ? n_qmin  : s_qmin[i];
    assign s_dig[i+1]   = s_go[i] ? n_dig   : s_dig[i];
    assign s_err[i+1]   = s_go[i] ? n_err   : s_err[i];
    assign s_go[i+1]    = s_go[i] && s_again[i];
  end

  // end-of-pattern verdict
  always_comb begin
    end_err  = err;
    end_grp  = grp;
    end_bref = bref;
    if (err == E_NONE) begin
      unique case (ph)
        PH_ESC: end_err = E_ESC_END;
        PH_DEC_NUM: if (num > bref) end_bref = num;
        PH_PROP_P, PH_PROP_FIRST, PH_PROP_NAME: end_err = E_PROPERTY;
        PH_UNI_U, PH_UNI_HEX4, PH_UNI_BR_FIRST, PH_UNI_BR: end_err = E_UNICODE;
        PH_HEX_U: end_err = E_HEX;
        PH_BR_OPEN, PH_BR_MIN, PH_BR_MAX: if (umode) end_err = E_INCOMPLETE;
        PH_GRP_OPEN, PH_GRP_Q, PH_GRP_LT: if (grp != CMAX) end_grp = grp + 1'b1;
        default: ;
      endcase
      if (end_err == E_NONE && cls) end_err = E_CLASS;
      if (end_err == E_NONE && umode && end_bref > {{(32-CW){1'b0}}, end_grp})
        end_err = E_DECIMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      umode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      umode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= PH_PLAIN; cls <= 1'b0; lq <= 1'b0; comma <= 1'b0;
      depth <= '0; grp <= '0; bref <= '0; num <= '0; qmin <= '0;
      dig <= '0; err <= E_NONE;
      out_valid <= 1'b0; error_code <= E_NONE; finished <= 1'b0;
      pattern_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (accept) begin
        out_valid <= 1'b1;
        if (operation == OP_END) begin
          error_code    <= end_err;
          finished      <= 1'b1;
          pattern_valid <= (end_err == E_NONE);
          ph <= PH_PLAIN; cls <= 1'b0; lq <= 1'b0; comma <= 1'b0;
          depth <= '0; grp <= '0; bref <= '0; num <= '0; qmin <= '0;
          dig <= '0; err <= E_NONE;
        end else begin
          error_code    <= s_err[STEPS];
          finished      <= 1'b0;
          pattern_valid <= 1'b0;
          ph <= s_ph[STEPS]; cls <= s_cls[STEPS]; lq <= s_lq[STEPS];
          comma <= s_comma[STEPS]; depth <= s_depth[STEPS]; grp <= s_grp[STEPS];
          bref <= s_bref[STEPS]; num <= s_num[STEPS]; qmin <= s_qmin[STEPS];
          dig <= s_dig[STEPS]; err <= s_err[STEPS];
        end
      end
    end
  end

  // a sticky error never clears except by an end beat
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != E_NONE && !(accept && operation == OP_END)) |=> (err == $past(err)))
    else $error("sticky error changed");

  // the verdict bit follows the code
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pattern_valid == (finished && error_code == E_NONE)))
    else $error("verdict mismatch");

  // an end beat leaves a clean scan state
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_END) |=> (err == E_NONE && ph == PH_PLAIN && depth == '0))
    else $error("state not cleared");

  // a byte beat reports the sticky error it leaves behind
  a_report: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_BYTE) |=> (error_code == err && !finished))
    else $error("byte result mismatch");

endmodule

### tb/tb_regexp_pattern_syntax_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_regexp_pattern_syntax_checker: self-checking bench for the syntax checker
// Streams directed and random patterns through the byte channel in both modes.
// A local model of the scanner predicts every output beat, and each output
// beat is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_regexp_pattern_syntax_checker
  import rpsc_pkg::*;
;

  localparam int CNT_W      = 16;
  localparam int STALL_MAX  = 9;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [3:0] code;
    logic       fin;
    logic       ok;
  } verdict_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       operation;
  logic [7:0] pattern_byte;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] error_code;
  logic       finished;
  logic       pattern_valid;

  regexp_pattern_syntax_checker #(.COUNTER_BITS(CNT_W)) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .pattern_byte(pattern_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .error_code(error_code), .finished(finished), .pattern_valid(pattern_valid)
  );

  // model state of the scanner
  logic             uni;
  phase_t           ph;
  logic             in_cls;
  logic             quant_ok;
  logic [CNT_W-1:0] depth;
  logic [CNT_W-1:0] groups;
  logic [31:0]      max_ref;
  logic [31:0]      num;
  logic [31:0]      qmin;
  logic             has_comma;
  logic [2:0]       ndig;
  logic [3:0]       err;

  verdict_t pending_q[$];
  int       fail_cnt;
  int       idle_cycles;
  int       patterns_done;
  int       patterns_ok;
  int       beats_in;
  bit       no_idle;

  // ---------------------------------------------------------------- model
  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit hex_ch(logic [7:0] c);
    return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit prop_ch(logic [7:0] c);
    return digit_ch(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
        || c == "=" || c == "-";
  endfunction

  // decimal accumulate, pinned at all ones on overflow
  function automatic logic [31:0] dec_sat(logic [31:0] v, logic [7:0] c);
    logic [63:0] s;
    s = 64'(v) * 10 + 64'(c - 8'h30);
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void note_err(logic [3:0] e);
    if (err == E_NONE) err = e;
  endfunction

  function automatic void bump(ref logic [CNT_W-1:0] v);
    if (v != {CNT_W{1'b1}}) v = v + 1'b1;
  endfunction

  function automatic void esc_close();
    ph = PH_PLAIN;
    if (!in_cls) quant_ok = 1'b1;
  endfunction

  function automatic void keep_ref();
    if (num > max_ref) max_ref = num;
  endfunction

  function automatic void clear_all();
    ph = PH_PLAIN; in_cls = 0; quant_ok = 0; depth = '0; groups = '0;
    max_ref = '0; num = '0; qmin = '0; has_comma = 0; ndig = '0; err = E_NONE;
  endfunction

  // bad brace: literal fallback in legacy mode, error in unicode mode
  function automatic bit brace_fallback();
    has_comma = 0;
    if (uni) begin
      note_err(E_INCOMPLETE);
      return 0;
    end
    quant_ok = 1;
    ph = PH_PLAIN;
    return 1;
  endfunction

  // one scan step; returns 1 when the byte must be looked at again
  function automatic bit scan_step(logic [7:0] c);
    case (ph)
      PH_PLAIN: begin
        if (c == "\\") begin ph = PH_ESC; return 0; end
        if (in_cls) begin
          if (c == "]") begin in_cls = 0; quant_ok = 1; end
          return 0;
        end
        if (c == "[") begin in_cls = 1; return 0; end
        if (c == "(") begin
          bump(depth); quant_ok = 1; ph = PH_GRP_OPEN; return 0;
        end
        if (c == ")") begin
          if (depth == 0) begin note_err(E_PAREN); return 0; end
          depth = depth - 1'b1; quant_ok = 1; return 0;
        end
        if (c == "{") begin ph = PH_BR_OPEN; return 0; end
        if (c == "*" || c == "+" || c == "?") begin
          if (!quant_ok) begin note_err(E_NOTHING); return 0; end
          quant_ok = 0; ph = PH_LAZY; return 0;
        end
        if ((c == "]" || c == "}") && uni) begin note_err(E_BRACKET); return 0; end
        quant_ok = 1;
        return 0;
      end
      PH_ESC: begin
        if (uni && digit_ch(c)) begin
          if (c == "0") ph = PH_DEC_ZERO;
          else begin num = 32'(c - 8'h30); ph = PH_DEC_NUM; end
        end else if (c == "p" || c == "P") ph = PH_PROP_P;
        else if (c == "u") ph = PH_UNI_U;
        else if (c == "x") begin ndig = 0; ph = uni ? PH_HEX_U : PH_HEX_N1; end
        else esc_close();
        return 0;
      end
      PH_DEC_ZERO: begin
        if (digit_ch(c)) begin note_err(E_DECIMAL); return 0; end
        esc_close();
        return 1;
      end
      PH_DEC_NUM: begin
        if (digit_ch(c)) begin num = dec_sat(num, c); return 0; end
        keep_ref(); esc_close();
        return 1;
      end
      PH_PROP_P: begin
        if (c == "{") ph = PH_PROP_FIRST; else note_err(E_PROPERTY);
        return 0;
      end
      PH_PROP_FIRST, PH_PROP_NAME: begin
        if (c == "}") begin
          if (ph == PH_PROP_FIRST) note_err(E_PROPERTY); else esc_close();
        end else if (prop_ch(c)) ph = PH_PROP_NAME;
        else note_err(E_PROPERTY);
        return 0;
      end
      PH_UNI_U: begin
        if (c == "{") ph = PH_UNI_BR_FIRST;
        else if (hex_ch(c)) begin ndig = 1; ph = PH_UNI_HEX4; end
        else note_err(E_UNICODE);
        return 0;
      end
      PH_UNI_HEX4: begin
        if (!hex_ch(c)) begin note_err(E_UNICODE); return 0; end
        ndig = ndig + 1'b1;
        if (ndig >= 4) begin ndig = 0; esc_close(); end
        return 0;
      end
      PH_UNI_BR_FIRST, PH_UNI_BR: begin
        if (c == "}") begin
          if (ph == PH_UNI_BR_FIRST) note_err(E_UNICODE); else esc_close();
        end else if (hex_ch(c)) ph = PH_UNI_BR;
        else note_err(E_UNICODE);
        return 0;
      end
      PH_HEX_U: begin
        if (!hex_ch(c)) begin note_err(E_HEX); return 0; end
        ndig = ndig + 1'b1;
        if (ndig >= 2) begin ndig = 0; esc_close(); end
        return 0;
      end
      PH_HEX_N1: begin
        if (hex_ch(c)) begin ph = PH_HEX_N2; return 0; end
        esc_close();
        return 1;
      end
      PH_HEX_N2: begin
        esc_close();
        return !hex_ch(c);
      end
      PH_BR_OPEN: begin
        if (!digit_ch(c)) return brace_fallback();
        qmin = 32'(c - 8'h30); has_comma = 0; ph = PH_BR_MIN;
        return 0;
      end
      PH_BR_MIN: begin
        if (digit_ch(c)) begin qmin = dec_sat(qmin, c); return 0; end
        if (c == ",") begin
          has_comma = 1; num = 0; ndig = 0; ph = PH_BR_MAX; return 0;
        end
        if (c == "}") begin quant_ok = 0; ph = PH_LAZY; return 0; end
        return brace_fallback();
      end
      PH_BR_MAX: begin
        if (digit_ch(c)) begin num = dec_sat(num, c); ndig = 1; return 0; end
        if (c != "}") return brace_fallback();
        if (ndig != 0 && num != 32'hFFFF_FFFF && qmin > num) begin
          note_err(E_ORDER); return 0;
        end
        has_comma = 0; ndig = 0; quant_ok = 0; ph = PH_LAZY;
        return 0;
      end
      PH_LAZY: begin
        ph = PH_PLAIN;
        return c != "?";
      end
      PH_GRP_OPEN: begin
        if (c == "?") begin ph = PH_GRP_Q; return 0; end
        bump(groups); ph = PH_PLAIN;
        return 1;
      end
      PH_GRP_Q: begin
        ph = PH_PLAIN;
        if (c == ":" || c == "=" || c == "!") return 0;
        if (c == "<") begin ph = PH_GRP_LT; return 0; end
        bump(groups);
        return !(c == "P" || c == "i" || c == "m" || c == "s" || c == "x");
      end
      PH_GRP_LT: begin
        ph = PH_PLAIN;
        if (c == "=" || c == "!") return 0;
        bump(groups);
        return 1;
      end
      default: begin
        ph = PH_PLAIN;
        return 1;
      end
    endcase
  endfunction

  function automatic void end_check();
    case (ph)
      PH_ESC:                                  note_err(E_ESC_END);
      PH_DEC_NUM:                              keep_ref();
      PH_PROP_P, PH_PROP_FIRST, PH_PROP_NAME:  note_err(E_PROPERTY);
      PH_UNI_U, PH_UNI_HEX4, PH_UNI_BR_FIRST, PH_UNI_BR: note_err(E_UNICODE);
      PH_HEX_U:                                note_err(E_HEX);
      PH_BR_OPEN, PH_BR_MIN, PH_BR_MAX:        if (uni) note_err(E_INCOMPLETE);
      PH_GRP_OPEN, PH_GRP_Q, PH_GRP_LT:        bump(groups);
      default: ;
    endcase
    if (in_cls) note_err(E_CLASS);
    if (uni && max_ref > 32'(groups)) note_err(E_DECIMAL);
  endfunction

  // expected output beat for one accepted input beat
  function automatic verdict_t predict_verdict(logic op, logic [7:0] c);
    verdict_t v;
    if (op == OP_BYTE) begin
      // a byte is scanned at most four times
      for (int i = 0; i < 4; i++) begin
        if (err != E_NONE) break;
        if (!scan_step(c)) break;
      end
      v = '{code: err, fin: 1'b0, ok: 1'b0};
    end else begin
      if (err == E_NONE) end_check();
      v = '{code: err, fin: 1'b1, ok: (err == E_NONE)};
      clear_all();
    end
    return v;
  endfunction

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- monitor
  // prediction on input acceptance, check on output acceptance, watchdog
  always @(posedge clk) begin
    verdict_t want;
    verdict_t expect_nxt;
    if (!rst) begin
      if (cfg_valid && cfg_ready) uni = cfg_data;
      if (in_valid && in_ready) begin
        expect_nxt = predict_verdict(operation, pattern_byte);
        pending_q.insert(pending_q.size(), expect_nxt);
        beats_in++;
      end
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: output beat with nothing expected (code %0d fin %0b ok %0b)",
                   $time, error_code, finished, pattern_valid);
          fail_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (error_code !== want.code) begin
            $display("%0t: error_code expected %0d actual %0d", $time, want.code, error_code);
            fail_cnt++;
          end
          if (finished !== want.fin) begin
            $display("%0t: finished expected %0b actual %0b", $time, want.fin, finished);
            fail_cnt++;
          end
          if (pattern_valid !== want.ok) begin
            $display("%0t: pattern_valid expected %0b actual %0b",
                     $time, want.ok, pattern_valid);
            fail_cnt++;
          end
          if (want.fin) begin
            patterns_done++;
            if (want.ok) patterns_ok++;
          end
        end
      end
      // watchdog: counts cycles without any handshake
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sink
  // random back-pressure, one draw per output beat, none while no_idle
  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, STALL_MAX);
      if (n > 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- driver
  // one input beat: random gap, then hold until accepted
  task automatic send_beat(logic op, logic [7:0] c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    operation    = op;
    pattern_byte = c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid     = 1'b0;
    operation    = $urandom_range(0, 1);
    pattern_byte = $urandom_range(0, 255);
  endtask

  task automatic send_pattern(string s);
    for (int i = 0; i < s.len(); i++) send_beat(OP_BYTE, s[i]);
    send_beat(OP_END, 8'h00);
  endtask

  // register write only once all outstanding beats are back
  task automatic set_mode(logic m);
    while (pending_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = m;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------- tests
  // short patterns hitting the edge cases, legacy mode then unicode mode
  task automatic test_directed();
    set_mode(1'b0);
    send_pattern("a{2,1");     // legacy: broken brace falls back to literals
    send_pattern("\\x4g*");    // short hex escape, rescanned byte quantifies
    send_pattern("*");         // nothing to repeat
    send_pattern(")");         // unmatched paren
    set_mode(1'b1);
    send_pattern("(a)\\2");    // backreference beyond group count
    send_pattern("]");         // lone bracket
    send_pattern("\\p{}");     // empty property
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_END, 8'h00);
  endtask

  // saturating accumulators, bounds: huge quantifier and backreference values
  task automatic test_saturation();
    set_mode(1'b1);
    send_pattern("a{99999999999,}");
    send_pattern("a{5,99999999999}");
    send_pattern("(x)\\99999999999");
    set_mode(1'b0);
    send_pattern("a{99999999999,3}");
  endtask

  function automatic string hex_digit();
    string hx;
    int k;
    hx = "0123456789abcdefABCDEF";
    k = $urandom_range(0, 21);
    return hx.substr(k, k);
  endfunction

  // one random token: mostly well-formed pieces, some broken or raw bytes
  function automatic string rand_token();
    string t;
    int k;
    k = $urandom_range(0, 29);
    case (k)
      0, 1:  t = $sformatf("%c", $urandom_range(8'h61, 8'h7a));
      2:     t = {"\\x", hex_digit(), hex_digit()};
      3:     t = {"\\u", hex_digit(), hex_digit(), hex_digit(), hex_digit()};
      4:     t = {"\\u{", hex_digit(), hex_digit(), "}"};
      5:     t = "\\p{Script=Latin}";
      6:     t = "(";
      7:     t = ")";
      8:     t = "(?:";
      9:     t = "(?<nm>";
      10:    t = "(?<=";
      11:    t = "(?!";
      12:    t = "[a-z\\]]";
      13:    t = "*";
      14:    t = "+?";
      15:    t = "?";
      16:    t = $sformatf("{%0d,%0d}", $urandom_range(0, 9), $urandom_range(0, 12));
      17:    t = $sformatf("{%0d}", $urandom_range(0, 99));
      18:    t = $sformatf("{%0d,}?", $urandom_range(0, 9));
      19:    t = $sformatf("\\%0d", $urandom_range(1, 5));
      20:    t = "\\0";
      21:    t = "\\d";
      22:    t = {"\\x", hex_digit()};
      23:    t = "{";
      24:    t = "]";
      25:    t = "}";
      26:    t = "(?i";
      27:    t = "\\";
      default: t = $sformatf("%c", $urandom_range(0, 255));
    endcase
    return t;
  endfunction

  // random patterns in one mode; returns after about n input beats
  task automatic test_random(logic m, int n, bit calm);
    string p;
    int start;
    set_mode(m);
    no_idle = calm;
    start = beats_in;
    while (beats_in - start < n) begin
      p = "";
      repeat ($urandom_range(1, 6)) p = {p, rand_token()};
      send_pattern(p);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    in_valid     = 1'b0;
    operation    = OP_BYTE;
    pattern_byte = 8'h00;
    no_idle      = 1'b0;
    fail_cnt     = 0;
    idle_cycles  = 0;
    beats_in     = 0;
    patterns_done = 0;
    patterns_ok  = 0;
    uni          = 1'b0;
    clear_all();
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_saturation();
    test_random(1'b0, 200, 1'b0);
    test_random(1'b1, 200, 1'b0);
    test_random(1'b0, 200, 1'b1);
    test_random(1'b1, 200, 1'b1);
    test_random(1'b0, 350, 1'b0);
    test_random(1'b1, 350, 1'b0);

    // drain, then a short settle window
    while (pending_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d input beats and %0d patterns in both modes, %0d accepted",
             beats_in, patterns_done, patterns_ok);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### regexp_pattern_syntax_checker.f
hw/rtl/rpsc_pkg.sv
hw/rtl/rpsc_scan.sv
hw/rtl/regexp_pattern_syntax_checker.sv
tb/tb_regexp_pattern_syntax_checker.sv
